FILE: rtl/core/sbl_pkg.sv
// Shared types and codes for the sorted byte list block.
// No dependencies; every other file in rtl/core imports this package.
package sbl_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DELETED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] entry;
        logic       entry_valid;
        logic       last;
    } t_res;

endpackage

FILE: rtl/core/sorted_byte_list.sv
// Top level of the sorted byte list: request queue in front of the list engine.
// Depends on sbl_pkg, sbl_req_fifo and sbl_list.
//
//   channel   valid         stall         payload
//   request   i_in_valid    o_in_stall    i_in_data  (t_req)
//   result    o_out_valid   i_out_stall   o_out_data (t_res)
//
// A request first updates the list, then the emitter presents one list cell
// per cycle while results are not stalled, max(count,1) results per request;
// no new request is taken until the last result of a run is accepted.
// Reset clears the entry count and the queue; no clearing pass is needed.
// Up to two requests queue up while results stall; the input stalls when both
// queue slots are taken.
module sorted_byte_list
    import sbl_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_data
);

    t_req   w_req;
    logic   w_q_valid;
    logic   w_pop;

    sbl_req_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_data     (w_req)
    );

    sbl_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_req       (w_req),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/sbl_req_fifo.sv
// Two-entry request queue that decouples the input channel from the list engine.
// Depends on sbl_pkg for the request type.
module sbl_req_fifo
    import sbl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_req   i_in_data,
    input  logic   i_pop,
    output logic   o_valid,
    output t_req   o_data
);

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_data     = r_mem[r_rptr];
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("request queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not grow on push");

endmodule

FILE: rtl/core/sbl_list.sv
// List engine: cells holding the sorted keys, an insert or delete on each pop,
// and a run emitter that rotates the occupied cells. Depends on sbl_pkg.
module sbl_list
    import sbl_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_req   i_req,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_res   o_out_data
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic [7:0]          r_cell [LIST_DEPTH];
    logic [7:0]          n_cell [LIST_DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic                r_state;
    logic                n_state;
    logic [LIST_DEPTH-1:0] w_lt;
    logic [LIST_DEPTH-1:0] w_eq;
    logic                w_found;
    logic                w_full;
    logic                w_update;
    logic                w_take;
    logic                w_last;

    assign w_update = (r_state == S_IDLE) && i_q_valid;
    assign o_pop    = w_update;
    assign w_take   = o_out_valid && !i_out_stall;
    assign w_full   = (r_count == CW'(LIST_DEPTH));
    assign w_last   = (r_count == '0) || (r_idx == r_count - CW'(1));
    assign w_found  = |w_eq;

    assign o_out_valid            = (r_state == S_EMIT);
    assign o_out_data.status      = r_status;
    assign o_out_data.entry       = (r_count == '0) ? 8'd0 : r_cell[0];
    assign o_out_data.entry_valid = (r_count != '0);
    assign o_out_data.last        = w_last;

    // Since the list is sorted, the entries below the key form a prefix and
    // the first entry that is not below the key is the insert or delete spot.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_lt[i] = (CW'(i) < r_count) && (r_cell[i] < i_req.key);
            w_eq[i] = (CW'(i) < r_count) && (r_cell[i] == i_req.key);
        end
    end

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_update) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status  = ST_INSERTED;
                            n_count   = r_count + CW'(1);
                            n_cell[0] = w_lt[0] ? r_cell[0] : i_req.key;
                            for (int i = 1; i < LIST_DEPTH; i++) begin
                                if (w_lt[i]) begin
                                    n_cell[i] = r_cell[i];
                                end else if (w_lt[i-1]) begin
                                    n_cell[i] = i_req.key;
                                end else begin
                                    n_cell[i] = r_cell[i-1];
                                end
                            end
                        end
                    end else begin
                        if (w_found) begin
                            n_status = ST_DELETED;
                            n_count  = r_count - CW'(1);
                            for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                                n_cell[i] = w_lt[i] ? r_cell[i] : r_cell[i+1];
                            end
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_take) begin
                    // Rotate the occupied cells so the next entry sits in cell 0;
                    // a full run of rotations restores the original order.
                    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                        if (CW'(i + 1) < r_count) begin
                            n_cell[i] = r_cell[i+1];
                        end else if (CW'(i + 1) == r_count) begin
                            n_cell[i] = r_cell[0];
                        end
                    end
                    if (w_full) begin
                        n_cell[LIST_DEPTH-1] = r_cell[0];
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_status <= n_status;
        r_idx    <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_state <= S_IDLE;
        end else begin
            r_count <= n_count;
            r_state <= n_state;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH)) else $error("entry count above depth");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_update |=> $stable(r_count)) else $error("count moved outside an update");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_count != '0) |-> (r_idx < r_count))
        else $error("emit index past list end");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_update && i_req.req_type == REQ_INSERT && !w_full)
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

endmodule
